FILE: hw/rtl/lpprb_pkg.sv
// Shared types, widths and codes for the length-prefixed packet ring buffer.
`timescale 1ns / 1ps

package lpprb_pkg;

   localparam int DEPTH        = 4096;
   localparam int PTR_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int BYTE_W       = 8;
   localparam int RING_SIZE_W  = 13;
   localparam int CHUNK_LEN_W  = 13;
   localparam int LEN_W        = 16;
   localparam int STATUS_W     = 2;
   localparam int STORED_W     = 13;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PACKET = 2'd2;

   typedef struct packed {
      logic                   func;
      logic [BYTE_W-1:0]      push_byte;
      logic                   chunk_first;
      logic [CHUNK_LEN_W-1:0] chunk_len;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   pop_byte;
      logic                last_of_packet;
      logic [LEN_W-1:0]    packet_len;
      logic [STORED_W-1:0] stored_count;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic mem_read;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;
   } stat_type;

endpackage

FILE: hw/rtl/lpprb_req_if.sv
// Request channel interface: valid/ready with one push or pop request.
`timescale 1ns / 1ps

interface lpprb_req_if;
   import lpprb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [BYTE_W-1:0]      push_byte;
   logic                   chunk_first;
   logic [CHUNK_LEN_W-1:0] chunk_len;

   modport source (output valid, output func, output push_byte, output chunk_first,
                   output chunk_len, input ready);
   modport sink   (input valid, input func, input push_byte, input chunk_first,
                   input chunk_len, output ready);
endinterface

FILE: hw/rtl/lpprb_rsp_if.sv
// Response channel interface: valid/ready with one result per request.
`timescale 1ns / 1ps

interface lpprb_rsp_if;
   import lpprb_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   pop_byte;
   logic                last_of_packet;
   logic [LEN_W-1:0]    packet_len;
   logic [STORED_W-1:0] stored_count;

   modport source (output valid, output status, output pop_byte, output last_of_packet,
                   output packet_len, output stored_count, input ready);
   modport sink   (input valid, input status, input pop_byte, input last_of_packet,
                   input packet_len, input stored_count, output ready);
endinterface

FILE: hw/rtl/length_prefixed_packet_ring_buffer.sv
// Top level of the length-prefixed packet ring buffer.
// A response is registered at the commit step, which follows the accept and memory read steps.
// Requests are handled one at a time (accept, registered memory read, commit);
// a held response stalls the commit step, and no new request is taken until it leaves.
// Reset: synchronous, active high; pointers, count, packet state and ring size
// (full depth) reset at once; the memory is not swept, so no clearing pass.
`timescale 1ns / 1ps

module length_prefixed_packet_ring_buffer (
   input  logic                              clock,
   input  logic                              reset,
   lpprb_req_if.sink                         req_ch,
   lpprb_rsp_if.source                       rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [lpprb_pkg::RING_SIZE_W-1:0] csr_write_data
);
   import lpprb_pkg::*;

   cmd_type      cmd;
   stat_type     stat;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   assign req_item.func        = req_ch.func;
   assign req_item.push_byte   = req_ch.push_byte;
   assign req_item.chunk_first = req_ch.chunk_first;
   assign req_item.chunk_len   = req_ch.chunk_len;
   assign req_ch.ready         = req_ready;

   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.status         = rsp_item.status;
   assign rsp_ch.pop_byte       = rsp_item.pop_byte;
   assign rsp_ch.last_of_packet = rsp_item.last_of_packet;
   assign rsp_ch.packet_len     = rsp_item.packet_len;
   assign rsp_ch.stored_count   = rsp_item.stored_count;

   lpprb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpprb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .req_item         (req_item),
      .rsp_item         (rsp_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ch.ready)
   );

endmodule

FILE: hw/rtl/lpprb_ctrl.sv
// Request sequencer: accept, memory read, commit.
`timescale 1ns / 1ps

module lpprb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpprb_pkg::stat_type stat,
   output lpprb_pkg::cmd_type  cmd
);
   import lpprb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.mem_read = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            // wait here while the previous response is still held
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/lpprb_dp.sv
// Datapath: ring memory, pointers, packet tracking and response register.
`timescale 1ns / 1ps

module lpprb_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [lpprb_pkg::RING_SIZE_W-1:0]     csr_write_data,
   input  lpprb_pkg::cmd_type                    cmd,
   output lpprb_pkg::stat_type                   stat,
   input  lpprb_pkg::req_item_type               req_item,
   output lpprb_pkg::rsp_item_type               rsp_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready
);
   import lpprb_pkg::*;

   localparam int EXT_W = ((CNT_W > RING_SIZE_W) ? CNT_W : RING_SIZE_W) + 1;
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                     input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      return (n >= size) ? '0 : n[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0] mem [DEPTH];

   req_item_type      item_ff;
   logic [BYTE_W-1:0] rd0_ff, rd1_ff;
   rsp_item_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]  eff_ff, eff_in;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [PTR_W-1:0]  back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic              chunk_ok_ff, chunk_ok_in;

   logic [EXT_W-1:0]       size_req;
   logic [CHUNK_LEN_W-1:0] clen;
   logic [EXT_W-1:0]       chunk_sum;
   logic [BYTE_W-1:0]      hdr_lo, hdr_hi;
   logic [LEN_W-1:0]       hlen;
   logic [LEN_W-1:0]       remain_eff, len_eff;
   logic                   pkt_ready;
   logic                   mem_write;
   logic [PTR_W-1:0]       front_next;

   assign front_next = ptr_advance(front_ff, eff_ff);

   // Ring size clamp
   always_comb begin
      size_req = EXT_W'(csr_write_data);
      if (size_req < EXT_W'(2)) begin
         eff_in = CNT_W'(2);
      end else if (size_req > EXT_W'(DEPTH)) begin
         eff_in = CNT_W'(DEPTH);
      end else begin
         eff_in = CNT_W'(csr_write_data);
      end
   end

   // Bytes outside the filled region are treated as zero, so the
   // header peek forces them to zero instead of clearing the memory.
   always_comb begin
      front_in    = front_ff;
      back_in     = back_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      cur_len_in  = cur_len_ff;
      chunk_ok_in = chunk_ok_ff;
      mem_write   = 1'b0;
      rsp_in      = '0;
      clen        = (item_ff.chunk_len == '0) ? CHUNK_LEN_W'(1) : item_ff.chunk_len;
      chunk_sum   = EXT_W'(clen) + EXT_W'(count_ff);
      hdr_lo      = (count_ff != '0) ? rd0_ff : '0;
      hdr_hi      = (count_ff > CNT_W'(1)) ? rd1_ff : '0;
      hlen        = {hdr_hi, hdr_lo};
      remain_eff  = remain_ff;
      len_eff     = cur_len_ff;
      pkt_ready   = 1'b1;

      if (item_ff.func == FUNC_PUSH) begin
         if (item_ff.chunk_first) begin
            chunk_ok_in = (chunk_sum <= EXT_W'(eff_ff));
         end
         if (chunk_ok_in && (count_ff < eff_ff)) begin
            mem_write = 1'b1;
            back_in   = ptr_advance(back_ff, eff_ff);
            count_in  = count_ff + CNT_W'(1);
            rsp_in.status = STATUS_OK;
         end else begin
            rsp_in.status = STATUS_REJECT;
         end
      end else begin
         if (remain_ff == '0) begin
            if ((hlen == '0) || (CMP_W'(hlen) > CMP_W'(count_ff))) begin
               pkt_ready = 1'b0;
            end else begin
               remain_eff = hlen;
               len_eff    = hlen;
            end
         end
         if (pkt_ready && (count_ff != '0)) begin
            front_in   = front_next;
            count_in   = count_ff - CNT_W'(1);
            remain_in  = remain_eff - LEN_W'(1);
            cur_len_in = len_eff;
            rsp_in.status         = STATUS_OK;
            rsp_in.pop_byte       = rd0_ff;
            rsp_in.last_of_packet = (remain_in == '0);
            rsp_in.packet_len     = len_eff;
         end else begin
            remain_in     = remain_eff;
            cur_len_in    = len_eff;
            rsp_in.status = STATUS_NO_PACKET;
         end
      end
      rsp_in.stored_count = STORED_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

   // Ring memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_write) begin
         mem[back_ff] <= item_ff.push_byte;
      end
      if (cmd.mem_read) begin
         rd0_ff <= mem[front_ff];
         rd1_ff <= mem[front_next];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff       <= CNT_W'(DEPTH);
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         cur_len_ff   <= '0;
         chunk_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            eff_ff      <= eff_in;
            front_ff    <= '0;
            back_ff     <= '0;
            count_ff    <= '0;
            remain_ff   <= '0;
            cur_len_ff  <= '0;
            chunk_ok_ff <= 1'b0;
         end else if (cmd.commit) begin
            front_ff    <= front_in;
            back_ff     <= back_in;
            count_ff    <= count_in;
            remain_ff   <= remain_in;
            cur_len_ff  <= cur_len_in;
            chunk_ok_ff <= chunk_ok_in;
         end
      end
   end

`ifndef SYNTH
   a_count_le_size: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eff_ff)
      else $error("byte count exceeds ring size");

   a_ptrs_in_ring: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(front_ff) < eff_ff) && (CNT_W'(back_ff) < eff_ff))
      else $error("ring pointer beyond ring size");

   a_commit_not_blocked: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("commit overwrote a held response");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response appeared without a commit");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !csr_write_enable && item_ff.func == FUNC_POP
       && rsp_in.status == STATUS_OK) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("successful pop did not drop the count");
`endif

endmodule
